### src/face_window_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// face window tracker assertion macros
// shared property forms for the tracker checks
// ----------------------------------------------------------------------------
`ifndef FACE_WINDOW_TRACKER_TOP_ASSERT_SVH
`define FACE_WINDOW_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FWT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fwt_pkg.sv
// ----------------------------------------------------------------------------
// face window tracker package
// widths, register indexes and the box arithmetic helpers
// ----------------------------------------------------------------------------
package fwt_pkg;

    localparam int unsigned COORD_LIMIT = 4096;
    localparam int unsigned COORD_W     = 12;
    localparam int unsigned DIM_W       = 13;
    localparam int unsigned SUM_W       = 13;

    localparam logic [DIM_W-1:0] FRAME_COLS_RESET = 13'd640;
    localparam logic [DIM_W-1:0] FRAME_ROWS_RESET = 13'd480;

    // configuration register indexes
    localparam logic REG_FRAME_COLS = 1'b0;
    localparam logic REG_FRAME_ROWS = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] pos;
        logic [COORD_W-1:0] size;
    } t_span;

    // floor(v / 5) by reciprocal multiply, exact for any 16-bit v
    function automatic logic [13:0] div5(input logic [15:0] v);
        logic [31:0] prod;
        prod = 32'(v) * 32'(16'hCCCD);
        return prod[31:18];
    endfunction

    // frame dimension to last valid coordinate: zero acts as one, saturate at limit
    function automatic logic [COORD_W-1:0] last_coord(input logic [DIM_W-1:0] dim);
        logic [COORD_W-1:0] r;
        if (dim == '0) begin
            r = '0;
        end else if (dim > DIM_W'(COORD_LIMIT)) begin
            r = COORD_W'(COORD_LIMIT - 1);
        end else begin
            r = COORD_W'(dim - 13'd1);
        end
        return r;
    endfunction

    // within ten percent: 10*|a-d| < a
    function automatic logic is_near(input logic [SUM_W-1:0] a, input logic [COORD_W-1:0] d);
        logic [SUM_W-1:0] diff;
        logic [16:0]      scaled;
        diff   = (a > SUM_W'(d)) ? (a - SUM_W'(d)) : (SUM_W'(d) - a);
        scaled = 17'(diff) * 17'd10;
        return scaled < 17'(a);
    endfunction

    // cut size so the span ends inside the frame
    function automatic logic [COORD_W-1:0] cut_size(input logic [COORD_W-1:0] pos,
                                                     input logic [SUM_W-1:0]   size,
                                                     input logic [COORD_W-1:0] lim);
        logic [COORD_W-1:0] r;
        if (14'(pos) + 14'(size) > 14'(lim)) begin
            r = lim - pos;
        end else begin
            r = size[COORD_W-1:0];
        end
        return r;
    endfunction

    // search window: pos = p - ceil(2s/5) floored at 0, size = floor(9s/5), clamped
    function automatic t_span grow(input logic [SUM_W-1:0]   p,
                                   input logic [COORD_W-1:0] s,
                                   input logic [COORD_W-1:0] lim);
        logic [13:0]        back;
        logic [13:0]        wide;
        logic [SUM_W-1:0]   q;
        logic [COORD_W-1:0] qc;
        t_span              r;
        back = div5(16'({s, 1'b0}) + 16'd4);
        wide = div5(16'(s) * 16'd9);
        q    = (p < SUM_W'(back)) ? '0 : (p - SUM_W'(back));
        qc   = (q > SUM_W'(lim)) ? lim : q[COORD_W-1:0];
        r.pos  = qc;
        r.size = cut_size(qc, SUM_W'(wide), lim);
        return r;
    endfunction

    // shown box: position clamped, size cut to the frame
    function automatic t_span place(input logic [SUM_W-1:0]   p,
                                    input logic [COORD_W-1:0] s,
                                    input logic [COORD_W-1:0] lim);
        logic [COORD_W-1:0] qc;
        t_span              r;
        qc     = (p > SUM_W'(lim)) ? lim : p[COORD_W-1:0];
        r.pos  = qc;
        r.size = cut_size(qc, SUM_W'(s), lim);
        return r;
    endfunction

endpackage

### src/face_window_tracker_top.sv
// ----------------------------------------------------------------------------
// face window tracker
// per-frame face box smoothing and search window placement
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) takes one request per video frame:
//   a found flag and the detected box. output channel (o_out_valid /
//   i_out_ready) returns one result per request: the shown box, the search
//   window for the next frame and the tracking / moving flags.
//   a request is captured in an input register, then the whole update is done
//   in one combinational pass into the tracker state, which is also the result
//   register. throughput is one request per cycle while the receiver takes
//   every result; the state feedback through that single pass sets the rate.
//   when the receiver stalls, the result holds and one more request waits in
//   the input register; further requests are refused until the result moves.
//   frame size is written through i_cfg_wr_en / i_cfg_idx / i_cfg_wdata
//   between requests. synchronous reset clears tracking, both boxes and the
//   flags and restores a 640 x 480 frame.
// ----------------------------------------------------------------------------
module face_window_tracker_top
    import fwt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_idx,
    input  logic [DIM_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_face_found,
    input  logic [COORD_W-1:0] i_face_x,
    input  logic [COORD_W-1:0] i_face_y,
    input  logic [COORD_W-1:0] i_face_w,
    input  logic [COORD_W-1:0] i_face_h,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_draw_x,
    output logic [COORD_W-1:0] o_draw_y,
    output logic [COORD_W-1:0] o_draw_w,
    output logic [COORD_W-1:0] o_draw_h,
    output logic [COORD_W-1:0] o_search_x,
    output logic [COORD_W-1:0] o_search_y,
    output logic [DIM_W-1:0]   o_search_w,
    output logic [DIM_W-1:0]   o_search_h,
    output logic               o_tracking,
    output logic               o_moving
);

    logic [DIM_W-1:0]   r_cols;
    logic [DIM_W-1:0]   r_rows;

    logic               r_in_valid;
    logic               r_in_found;
    logic [COORD_W-1:0] r_in_x, r_in_y, r_in_w, r_in_h;

    logic               r_out_valid;
    logic               r_trk, r_mov;
    logic [COORD_W-1:0] r_box_x, r_box_y, r_box_w, r_box_h;
    logic [COORD_W-1:0] r_win_x, r_win_y, r_win_w, r_win_h;

    logic               n_trk, n_mov;
    logic [COORD_W-1:0] n_box_x, n_box_y, n_box_w, n_box_h;
    logic [COORD_W-1:0] n_win_x, n_win_y, n_win_w, n_win_h;

    logic               advance;
    logic [COORD_W-1:0] lim_x, lim_y;
    logic [SUM_W-1:0]   abs_x, abs_y;
    logic               steady;
    t_span              grow_x, grow_y, place_x, place_y;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= FRAME_COLS_RESET;
            r_rows <= FRAME_ROWS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_FRAME_COLS: r_cols <= i_cfg_wdata;
                REG_FRAME_ROWS: r_rows <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake: state advances when the result slot is free or being taken
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_found <= i_face_found;
            r_in_x     <= i_face_x;
            r_in_y     <= i_face_y;
            r_in_w     <= i_face_w;
            r_in_h     <= i_face_h;
        end
    end

    // absolute position: offset by the old window only while tracking
    always_comb begin
        lim_x   = last_coord(r_cols);
        lim_y   = last_coord(r_rows);
        abs_x   = SUM_W'(r_in_x) + (r_trk ? SUM_W'(r_win_x) : '0);
        abs_y   = SUM_W'(r_in_y) + (r_trk ? SUM_W'(r_win_y) : '0);
        steady  = is_near(abs_x, r_box_x) && is_near(abs_y, r_box_y) &&
                  is_near(SUM_W'(r_in_w), r_box_w) && is_near(SUM_W'(r_in_h), r_box_h);
        grow_x  = grow(abs_x, r_in_w, lim_x);
        grow_y  = grow(abs_y, r_in_h, lim_y);
        place_x = place(abs_x, r_in_w, lim_x);
        place_y = place(abs_y, r_in_h, lim_y);
    end

    // next tracker state
    always_comb begin
        n_trk   = r_trk;
        n_mov   = r_mov;
        n_box_x = r_box_x;
        n_box_y = r_box_y;
        n_box_w = r_box_w;
        n_box_h = r_box_h;
        n_win_x = r_win_x;
        n_win_y = r_win_y;
        n_win_w = r_win_w;
        n_win_h = r_win_h;
        if (!r_in_found) begin
            n_trk = 1'b0;
        end else begin
            n_win_x = grow_x.pos;
            n_win_w = grow_x.size;
            n_win_y = grow_y.pos;
            n_win_h = grow_y.size;
            if (r_trk) begin
                n_mov = !steady;
                if (!steady) begin
                    n_box_x = place_x.pos;
                    n_box_w = place_x.size;
                    n_box_y = place_y.pos;
                    n_box_h = place_y.size;
                end
            end else begin
                // first hit: raw detection is shown as is
                n_trk   = 1'b1;
                n_mov   = 1'b1;
                n_box_x = r_in_x;
                n_box_y = r_in_y;
                n_box_w = r_in_w;
                n_box_h = r_in_h;
            end
        end
    end

    // tracker state, doubling as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_trk       <= 1'b0;
            r_mov       <= 1'b0;
            r_box_x     <= '0;
            r_box_y     <= '0;
            r_box_w     <= '0;
            r_box_h     <= '0;
            r_win_x     <= '0;
            r_win_y     <= '0;
            r_win_w     <= '0;
            r_win_h     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_trk       <= n_trk;
                r_mov       <= n_mov;
                r_box_x     <= n_box_x;
                r_box_y     <= n_box_y;
                r_box_w     <= n_box_w;
                r_box_h     <= n_box_h;
                r_win_x     <= n_win_x;
                r_win_y     <= n_win_y;
                r_win_w     <= n_win_w;
                r_win_h     <= n_win_h;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result ports
    assign o_out_valid = r_out_valid;
    assign o_draw_x    = r_box_x;
    assign o_draw_y    = r_box_y;
    assign o_draw_w    = r_box_w;
    assign o_draw_h    = r_box_h;
    assign o_search_x  = r_win_x;
    assign o_search_y  = r_win_y;
    assign o_search_w  = DIM_W'(r_win_w);
    assign o_search_h  = DIM_W'(r_win_h);
    assign o_tracking  = r_trk;
    assign o_moving    = r_mov;

    // checks
`include "face_window_tracker_top_assert.svh"

    `FWT_ASSERT_NEXT(a_adv_gives_result, i_clk, i_rst_n, advance, r_out_valid, "no result after update")
    `FWT_ASSERT_NEXT(a_found_tracks, i_clk, i_rst_n, advance && r_in_found, r_trk, "detection did not start tracking")
    `FWT_ASSERT_NEXT(a_first_hit_moves, i_clk, i_rst_n, advance && r_in_found && !r_trk, r_mov, "first hit not flagged moving")
    `FWT_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in_x), "input stage lost a request")

endmodule

### sim/face_window_tracker_top_test.sv
// ----------------------------------------------------------------------------
// face window tracker testbench
// drives detection requests through the valid/ready input channel and checks
// every result against a cycle-free model of the tracker: a directed table of
// corner cases first, then random tracking sequences under several frame
// sizes and idle patterns on both channels
// ----------------------------------------------------------------------------
module face_window_tracker_top_test
    import fwt_pkg::*;
();

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_face_req;

    typedef struct packed {
        logic [COORD_W-1:0] draw_x;
        logic [COORD_W-1:0] draw_y;
        logic [COORD_W-1:0] draw_w;
        logic [COORD_W-1:0] draw_h;
        logic [COORD_W-1:0] search_x;
        logic [COORD_W-1:0] search_y;
        logic [DIM_W-1:0]   search_w;
        logic [DIM_W-1:0]   search_h;
        logic               tracking;
        logic               moving;
    } t_track_result;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam int DIR_ROWS       = 21;
    localparam int DIR_COLS       = 16;
    localparam int PHASES         = 9;
    localparam int PHASE_REQS     = 190;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int COORD_MAX      = 4095;

    // frame size per phase; a nonzero random bound replaces the fixed pair
    localparam int PHASE_COLS[PHASES]  = '{320, 4096, 1, 8191, 0, 640, 640, 1920, 4097};
    localparam int PHASE_ROWS[PHASES]  = '{240, 4096, 1, 0, 8191, 480, 480, 1080, 4095};
    localparam int PHASE_RAND[PHASES]  = '{0, 0, 0, 0, 0, 4096, 200, 0, 0};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic               i_cfg_idx;
    logic [DIM_W-1:0]   i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_face_found;
    logic [COORD_W-1:0] i_face_x;
    logic [COORD_W-1:0] i_face_y;
    logic [COORD_W-1:0] i_face_w;
    logic [COORD_W-1:0] i_face_h;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [COORD_W-1:0] o_draw_x;
    logic [COORD_W-1:0] o_draw_y;
    logic [COORD_W-1:0] o_draw_w;
    logic [COORD_W-1:0] o_draw_h;
    logic [COORD_W-1:0] o_search_x;
    logic [COORD_W-1:0] o_search_y;
    logic [DIM_W-1:0]   o_search_w;
    logic [DIM_W-1:0]   o_search_h;
    logic               o_tracking;
    logic               o_moving;

    // tracker model state
    logic [DIM_W-1:0] cfg_cols;
    logic [DIM_W-1:0] cfg_rows;
    bit               trk;
    bit               mov;
    int               box_x, box_y, box_w, box_h;
    int               srch_x, srch_y, srch_w, srch_h;

    t_track_result results_due[$];
    t_idle_mode    idle_mode;
    int            fail_count;
    int            fields_checked;
    int            idle_cycles;
    int            n_requests;
    int            n_found;
    int            n_steady;

    // directed table: found, x, y, w, h, typed, then the typed result
    // draw x/y/w/h, search x/y/w/h, tracking, moving
    int dir_table[DIR_ROWS][DIR_COLS] = '{
        '{0,    0,    0,    0,    0, 1,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{1,  100,   50,   40,   30, 1,  100,   50,   40,   30,  84,  38, 72, 54, 1, 1},
        '{1,   16,   12,   40,   30, 1,  100,   50,   40,   30,  84,  38, 72, 54, 1, 0},
        '{1,   20,   12,   40,   30, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{1,   40,   12,   40,   30, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{1,   16,   12,   44,   30, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{0, 4095, 4095, 4095, 4095, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{1, 4095, 4095, 4095, 4095, 1, 4095, 4095, 4095, 4095, 639, 479,  0,  0, 1, 1},
        '{1, 4095, 4095, 4095, 4095, 1,  639,  479,    0,    0, 639, 479,  0,  0, 1, 1},
        '{0,    0,    0,    0,    0, 1,  639,  479,    0,    0, 639, 479,  0,  0, 0, 1},
        '{1,    0,    0,    0,    0, 1,    0,    0,    0,    0,   0,   0,  0,  0, 1, 1},
        '{1,    0,    0,    0,    0, 1,    0,    0,    0,    0,   0,   0,  0,  0, 1, 1},
        '{0,    0,    0,    0,    0, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{1,    0,    0,    1,    1, 1,    0,    0,    1,    1,   0,   0,  1,  1, 1, 1},
        '{1,    0,    0,    1,    1, 1,    0,    0,    1,    1,   0,   0,  1,  1, 1, 1},
        '{0,    0,    0,    0,    0, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{1,    1,    1,    5,    5, 1,    1,    1,    5,    5,   0,   0,  9,  9, 1, 1},
        '{1,  600,  400,  100,  100, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{1, 2730, 1365, 1365, 2730, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{0,    0,    0,    0,    0, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0},
        '{1, 1365, 2730, 2730, 1365, 0,    0,    0,    0,    0,   0,   0,  0,  0, 0, 0}
    };

    face_window_tracker_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_face_found (i_face_found),
        .i_face_x     (i_face_x),
        .i_face_y     (i_face_y),
        .i_face_w     (i_face_w),
        .i_face_h     (i_face_h),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_draw_x     (o_draw_x),
        .o_draw_y     (o_draw_y),
        .o_draw_w     (o_draw_w),
        .o_draw_h     (o_draw_h),
        .o_search_x   (o_search_x),
        .o_search_y   (o_search_y),
        .o_search_w   (o_search_w),
        .o_search_h   (o_search_h),
        .o_tracking   (o_tracking),
        .o_moving     (o_moving)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // frame dimension as the clamp sees it
    function automatic int frame_span(logic [DIM_W-1:0] dim);
        if (dim == '0) return 1;
        if (int'(dim) > COORD_LIMIT) return COORD_LIMIT;
        return int'(dim);
    endfunction

    // 10*|a-d| < a, never true for a zero value
    function automatic bit close_enough(int a, int d);
        int diff;
        diff = (a > d) ? a - d : d - a;
        return 10 * diff < a;
    endfunction

    // search window span: back off by 0.4 s, widen to 1.8 s, keep inside the frame
    function automatic void widen(input int p, input int s, input int lim,
                                  output int q, output int z);
        int n;
        n = 5 * p - 2 * s;
        q = (n < 0) ? 0 : n / 5;
        z = (9 * s) / 5;
        if (q > lim - 1) q = lim - 1;
        if (q + z > lim - 1) z = lim - 1 - q;
    endfunction

    // shown box span: clamp position, cut size at the frame edge
    function automatic void clamp_span(input int p, input int s, input int lim,
                                       output int q, output int z);
        q = (p < 0) ? 0 : p;
        z = s;
        if (q > lim - 1) q = lim - 1;
        if (q + z > lim - 1) z = lim - 1 - q;
    endfunction

    // advance the tracker model by one request and return the result it shows
    function automatic t_track_result advance_tracker(t_face_req r);
        int            cols;
        int            rows;
        int            ax;
        int            ay;
        bit            steady;
        t_track_result o;
        cols = frame_span(cfg_cols);
        rows = frame_span(cfg_rows);
        if (!r.found) begin
            trk = 1'b0;
        end else if (trk) begin
            ax = srch_x + int'(r.x);
            ay = srch_y + int'(r.y);
            steady = close_enough(ax, box_x) && close_enough(ay, box_y) &&
                     close_enough(int'(r.w), box_w) && close_enough(int'(r.h), box_h);
            if (!steady) begin
                clamp_span(ax, int'(r.w), cols, box_x, box_w);
                clamp_span(ay, int'(r.h), rows, box_y, box_h);
            end
            widen(ax, int'(r.w), cols, srch_x, srch_w);
            widen(ay, int'(r.h), rows, srch_y, srch_h);
            mov = !steady;
        end else begin
            // first hit takes the raw detection
            trk   = 1'b1;
            mov   = 1'b1;
            box_x = int'(r.x);
            box_y = int'(r.y);
            box_w = int'(r.w);
            box_h = int'(r.h);
            widen(box_x, box_w, cols, srch_x, srch_w);
            widen(box_y, box_h, rows, srch_y, srch_h);
        end
        o.draw_x   = COORD_W'(box_x);
        o.draw_y   = COORD_W'(box_y);
        o.draw_w   = COORD_W'(box_w);
        o.draw_h   = COORD_W'(box_h);
        o.search_x = COORD_W'(srch_x);
        o.search_y = COORD_W'(srch_y);
        o.search_w = DIM_W'(srch_w);
        o.search_h = DIM_W'(srch_h);
        o.tracking = trk;
        o.moving   = mov;
        return o;
    endfunction

    function automatic int fit_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    // value inside the ten percent band around d, or a jump somewhere in range
    function automatic int aim(int d, int span, bit keep);
        int j;
        j = d / 11;
        if (keep || $urandom_range(1, 0) == 1) return d - j + int'($urandom_range(2 * j, 0));
        return int'($urandom_range(span, 0));
    endfunction

    // random request: mostly coherent tracking sequences, some drops and noise
    function automatic t_face_req pick_face_req();
        t_face_req r;
        int        roll;
        int        cols;
        int        rows;
        bit        keep;
        cols    = frame_span(cfg_cols);
        rows    = frame_span(cfg_rows);
        roll    = int'($urandom_range(99, 0));
        r.found = 1'b1;
        r.x     = COORD_W'($urandom);
        r.y     = COORD_W'($urandom);
        r.w     = COORD_W'($urandom);
        r.h     = COORD_W'($urandom);
        if (roll < 6) begin
            r.found = 1'b0;
        end else if (roll < 12) begin
            // raw noise, all fields random
        end else if (!trk) begin
            r.x = COORD_W'(fit_coord(int'($urandom_range(cols - 1, 0))));
            r.y = COORD_W'(fit_coord(int'($urandom_range(rows - 1, 0))));
            r.w = COORD_W'(fit_coord(int'($urandom_range(cols / 3 + 1, 1))));
            r.h = COORD_W'(fit_coord(int'($urandom_range(rows / 3 + 1, 1))));
        end else begin
            keep = ($urandom_range(99, 0) < 70);
            r.x = COORD_W'(fit_coord(aim(box_x, cols, keep) - srch_x));
            r.y = COORD_W'(fit_coord(aim(box_y, rows, keep) - srch_y));
            r.w = COORD_W'(fit_coord(aim(box_w, cols / 2 + 1, keep)));
            r.h = COORD_W'(fit_coord(aim(box_h, rows / 2 + 1, keep)));
        end
        return r;
    endfunction

    // send one request, record what it should show once accepted
    task automatic send_face(t_face_req r, bit typed, t_track_result typed_res);
        int            gap_pct;
        t_track_result want;
        gap_pct = (idle_mode == IDLE_SEND) ? 67 : ((idle_mode == IDLE_BOTH) ? 8 : 0);
        while (int'($urandom_range(99, 0)) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_face_found = r.found;
        i_face_x     = r.x;
        i_face_y     = r.y;
        i_face_w     = r.w;
        i_face_h     = r.h;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        want = advance_tracker(r);
        if (typed) want = typed_res;
        results_due.push_back(want);
        n_requests++;
        if (r.found) n_found++;
        if (want.tracking && !want.moving) n_steady++;
        @(negedge i_clk);
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain(int settle);
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // frame size write, both registers, model follows
    task automatic set_frame(logic [DIM_W-1:0] cols, logic [DIM_W-1:0] rows);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx   = REG_FRAME_COLS;
        i_cfg_wdata = cols;
        @(negedge i_clk);
        i_cfg_idx   = REG_FRAME_ROWS;
        i_cfg_wdata = rows;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        cfg_cols    = cols;
        cfg_rows    = rows;
    endtask

    task automatic check_field(string label, int want, int got);
        fields_checked++;
        if (want != got) begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECV: i_out_ready <= ($urandom_range(99, 0) >= 67);
            IDLE_BOTH: i_out_ready <= ($urandom_range(99, 0) >= 8);
            default:   i_out_ready <= 1'b1;
        endcase
    end

    // result check against the oldest outstanding request
    t_track_result got_res;
    t_track_result want_res;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_res = {o_draw_x, o_draw_y, o_draw_w, o_draw_h, o_search_x, o_search_y,
                       o_search_w, o_search_h, o_tracking, o_moving};
            if (results_due.size() == 0) begin
                fail_count++;
                $display("%0t: result with no request outstanding", $time);
            end else begin
                want_res = results_due.pop_front();
                check_field("draw_x", want_res.draw_x, got_res.draw_x);
                check_field("draw_y", want_res.draw_y, got_res.draw_y);
                check_field("draw_w", want_res.draw_w, got_res.draw_w);
                check_field("draw_h", want_res.draw_h, got_res.draw_h);
                check_field("search_x", want_res.search_x, got_res.search_x);
                check_field("search_y", want_res.search_y, got_res.search_y);
                check_field("search_w", want_res.search_w, got_res.search_w);
                check_field("search_h", want_res.search_h, got_res.search_h);
                check_field("tracking", want_res.tracking, got_res.tracking);
                check_field("moving", want_res.moving, got_res.moving);
            end
        end
    end

    // cycles without progress on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // main sequence
    initial begin
        t_face_req     req;
        t_track_result typed_res;
        int            cols;
        int            rows;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_idx      = REG_FRAME_COLS;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_out_ready    = 1'b1;
        i_face_found   = 1'b0;
        i_face_x       = '0;
        i_face_y       = '0;
        i_face_w       = '0;
        i_face_h       = '0;
        idle_mode      = IDLE_NONE;
        fail_count     = 0;
        fields_checked = 0;
        idle_cycles    = 0;
        n_requests     = 0;
        n_found        = 0;
        n_steady       = 0;
        cfg_cols       = FRAME_COLS_RESET;
        cfg_rows       = FRAME_ROWS_RESET;
        trk            = 1'b0;
        mov            = 1'b0;
        {box_x, box_y, box_w, box_h}     = '0;
        {srch_x, srch_y, srch_w, srch_h} = '0;

        // reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table at the reset frame size
        for (int i = 0; i < DIR_ROWS; i++) begin
            req.found = 1'(dir_table[i][0]);
            req.x     = COORD_W'(dir_table[i][1]);
            req.y     = COORD_W'(dir_table[i][2]);
            req.w     = COORD_W'(dir_table[i][3]);
            req.h     = COORD_W'(dir_table[i][4]);
            typed_res = {COORD_W'(dir_table[i][6]), COORD_W'(dir_table[i][7]),
                         COORD_W'(dir_table[i][8]), COORD_W'(dir_table[i][9]),
                         COORD_W'(dir_table[i][10]), COORD_W'(dir_table[i][11]),
                         DIM_W'(dir_table[i][12]), DIM_W'(dir_table[i][13]),
                         1'(dir_table[i][14]), 1'(dir_table[i][15])};
            send_face(req, dir_table[i][5] != 0, typed_res);
        end
        i_in_valid = 1'b0;

        // random phases, one frame size and idle pattern each
        for (int p = 0; p < PHASES; p++) begin
            drain(4);
            cols = PHASE_COLS[p];
            rows = PHASE_ROWS[p];
            if (PHASE_RAND[p] != 0) begin
                cols = int'($urandom_range(PHASE_RAND[p], 1));
                rows = int'($urandom_range(PHASE_RAND[p], 1));
            end
            set_frame(DIM_W'(cols), DIM_W'(rows));
            idle_mode = t_idle_mode'(p % 4);
            for (int n = 0; n < PHASE_REQS; n++)
                send_face(pick_face_req(), 1'b0, '0);
            i_in_valid = 1'b0;
        end

        idle_mode = IDLE_NONE;
        drain(10);
        $display("covered %0d requests (%0d from the table), %0d with a face, %0d held steady,",
                 n_requests, DIR_ROWS, n_found, n_steady);
        $display("over %0d frame sizes and four idle patterns; %0d fields checked, %0d mismatches",
                 PHASES + 1, fields_checked, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/fwt_pkg.sv
src/face_window_tracker_top.sv
sim/face_window_tracker_top_test.sv
